// ----- src/tcoq_pkg.sv -----
package tcoq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int MAX_RESULTS = 64;
	localparam int ID_W = 16;
	localparam int VAL_W = 24;
	localparam int TIME_W = 16;
	localparam int COUNT_W = 7;
	localparam int SUM_W = 22;
	localparam logic [SUM_W-1:0] SUM_LIMIT = '1;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MARK,
		S_SHIFT,
		S_SCAN,
		S_STATS,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [VAL_W-1:0]  value;
		logic [TIME_W-1:0] ptime;
		logic              cls;
	} entry_t;

	// per-cycle command from the sequencer to every cell
	typedef enum logic [1:0] {
		C_HOLD,
		C_INS,
		C_DEL,
		C_ROT
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [ID_W-1:0]  key;
		entry_t           new_entry;
	} cell_ctl_t;

endpackage

// ----- src/tcoq_cell.sv -----
// one queue slot: holds an entry, takes its neighbor's on shifts
module tcoq_cell (
	input  logic                clk,
	input  tcoq_pkg::cell_ctl_t ctl,
	input  logic                occ,
	input  logic                ins_here,
	input  logic                ins_above,
	input  logic                del_at_or_below,
	input  tcoq_pkg::entry_t    prev_entry,
	input  tcoq_pkg::entry_t    next_entry,
	output tcoq_pkg::entry_t    entry,
	output logic                hit
);

	tcoq_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			tcoq_pkg::C_INS: begin
				if (ins_here) begin
					entry_q <= ctl.new_entry;
				end else if (ins_above) begin
					entry_q <= prev_entry;
				end
			end
			tcoq_pkg::C_DEL: begin
				if (del_at_or_below) begin
					entry_q <= next_entry;
				end
			end
			tcoq_pkg::C_ROT: entry_q <= next_entry;
			default: entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign hit   = occ && (entry_q.id == ctl.key);

endmodule

// ----- src/two_class_order_queue.sv -----
// channel  | valid     | ready     | payload
// in       | in_valid  | in_ready  | op, order_id, order_value, prep_time, urgent
// out      | out_valid | out_ready | status, found_value, found_time, entry_count,
//          |           |           | time_sum, time_max, last
// insert or remove with a match: mark, shift, totals pass, then the registered result
// full insert, missed remove, unused op or missed search: mark, totals pass, then the result
// search with matches: a totals pass, then a rotation that emits each match in queue order;
//   no new transaction is accepted until the rotation ends
// a held result that is not taken stalls the rotation or the final load
// reset clears occupancy, control and out valid; entry storage is not cleared
module two_class_order_queue #(
	parameter int DEPTH = tcoq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] order_id,
	input  logic [23:0] order_value,
	input  logic [15:0] prep_time,
	input  logic        urgent,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [23:0] found_value,
	output logic [15:0] found_time,
	output logic [6:0]  entry_count,
	output logic [21:0] time_sum,
	output logic [15:0] time_max,
	output logic        last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tcoq_pkg::state_t  state_q, state_d;
	tcoq_pkg::op_t     op_q;
	logic [15:0]       key_q;
	tcoq_pkg::entry_t  new_q;
	logic [CW-1:0]     occ_q;
	logic [IW-1:0]     pos_q;
	logic              hit_any_q;
	logic              full_q;
	logic [CW-1:0]     rot_q;
	logic [6:0]        nres_q;
	logic [6:0]        nmatch_q;
	logic [21:0]       sum_q;
	logic [15:0]       max_q;

	tcoq_pkg::entry_t  ent [DEPTH];
	logic [DEPTH-1:0]  hits;
	logic [DEPTH-1:0]  occv;
	tcoq_pkg::cell_ctl_t ctl;

	logic              rot_done;
	logic              rot_en;
	logic              cur_live;
	logic              cur_hit;
	logic              emit_hit;
	logic              emit_end;
	logic              load_out;
	logic [6:0]        cnt_now;

	// output register
	logic              ov_q;
	tcoq_pkg::status_t st_q;
	logic [23:0]       fv_q;
	logic [15:0]       ft_q;
	logic [6:0]        cnt_q;
	logic [21:0]       tsum_q;
	logic [15:0]       tmax_q;
	logic              last_q;
	logic              out_free;

	assign out_free = !ov_q || out_ready;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic ins_here, ins_above, del_le;
			assign occv[g]   = (CW'(g) < occ_q);
			assign ins_here  = (pos_q == IW'(g));
			assign ins_above = (IW'(g) > pos_q) && (CW'(g) <= occ_q);
			assign del_le    = (IW'(g) >= pos_q);
			tcoq_cell u_cell (
				.clk             (clk),
				.ctl             (ctl),
				.occ             (occv[g]),
				.ins_here        (ins_here),
				.ins_above       (ins_above),
				.del_at_or_below (del_le),
				.prev_entry      (ent[(g + DEPTH - 1) % DEPTH]),
				.next_entry      (ent[(g + 1) % DEPTH]),
				.entry           (ent[g]),
				.hit             (hits[g])
			);
		end
	endgenerate

	// insert position is the first normal entry for an urgent order, else the tail
	logic [IW-1:0] ins_pos, del_pos;
	logic          ins_found;
	logic          del_hit;
	always_comb begin
		ins_pos   = occ_q[IW-1:0];
		ins_found = 1'b0;
		del_pos   = '0;
		del_hit   = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (!ins_found && occv[i] && !ent[i].cls && new_q.cls) begin
				ins_pos   = IW'(i);
				ins_found = 1'b1;
			end
			if (hits[i]) begin
				del_pos = IW'(i);
				del_hit = 1'b1;
			end
		end
	end

	// row rotates during the totals pass and while scanning; after k steps cell 0 holds entry k
	assign rot_done = (rot_q == CW'(DEPTH));
	assign rot_en   = ((state_q == tcoq_pkg::S_STATS) ||
		(state_q == tcoq_pkg::S_SCAN && out_free)) && !rot_done;
	assign cur_live = (rot_q < occ_q);
	assign cur_hit  = cur_live && (ent[0].id == key_q);
	assign emit_hit = (state_q == tcoq_pkg::S_SCAN) && rot_en && cur_hit &&
		(nres_q != nmatch_q);
	assign emit_end = (state_q == tcoq_pkg::S_EMIT) && out_free;
	assign load_out = emit_hit || emit_end;
	assign cnt_now  = (occ_q > CW'(tcoq_pkg::COUNT_LIMIT)) ? tcoq_pkg::COUNT_LIMIT :
		7'(occ_q);

	always_comb begin
		in_ready      = (state_q == tcoq_pkg::S_IDLE);
		ctl.key       = key_q;
		ctl.new_entry = new_q;
		ctl.cmd       = tcoq_pkg::C_HOLD;
		if (state_q == tcoq_pkg::S_SHIFT) begin
			ctl.cmd = (op_q == tcoq_pkg::OP_INSERT) ? tcoq_pkg::C_INS : tcoq_pkg::C_DEL;
		end else if (rot_en) begin
			ctl.cmd = tcoq_pkg::C_ROT;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcoq_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = tcoq_pkg::S_MARK;
				end
			end
			tcoq_pkg::S_MARK: begin
				case (op_q)
					tcoq_pkg::OP_INSERT: state_d = (occ_q >= CW'(DEPTH)) ?
						tcoq_pkg::S_STATS : tcoq_pkg::S_SHIFT;
					tcoq_pkg::OP_REMOVE: state_d = del_hit ?
						tcoq_pkg::S_SHIFT : tcoq_pkg::S_STATS;
					default: state_d = tcoq_pkg::S_STATS;
				endcase
			end
			tcoq_pkg::S_SHIFT: state_d = tcoq_pkg::S_STATS;
			tcoq_pkg::S_STATS: begin
				if (rot_done) begin
					state_d = (op_q == tcoq_pkg::OP_SEARCH && nmatch_q != '0) ?
						tcoq_pkg::S_SCAN : tcoq_pkg::S_EMIT;
				end
			end
			tcoq_pkg::S_SCAN: begin
				if (rot_done) begin
					state_d = tcoq_pkg::S_IDLE;
				end
			end
			tcoq_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = tcoq_pkg::S_IDLE;
				end
			end
			default: state_d = tcoq_pkg::S_IDLE;
		endcase
	end

	// stored-entry sum seen this rotation
	logic [22:0] sum_next;
	assign sum_next = {1'b0, sum_q} + 23'(ent[0].ptime);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcoq_pkg::S_IDLE;
			occ_q   <= '0;
			ov_q    <= 1'b0;
			rot_q   <= '0;
			nres_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (state_q == tcoq_pkg::S_SHIFT) begin
				if (op_q == tcoq_pkg::OP_INSERT) begin
					occ_q <= occ_q + 1'b1;
				end else begin
					occ_q <= occ_q - 1'b1;
				end
			end
			if (state_q == tcoq_pkg::S_IDLE || (state_q == tcoq_pkg::S_STATS && rot_done)) begin
				rot_q <= '0;
			end else if (rot_en) begin
				rot_q <= rot_q + 1'b1;
			end
			if (state_q == tcoq_pkg::S_IDLE) begin
				nres_q <= '0;
			end else if (emit_hit) begin
				nres_q <= nres_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcoq_pkg::S_IDLE && in_valid) begin
			op_q  <= tcoq_pkg::op_t'(op);
			key_q <= order_id;
			new_q <= '{id: order_id, value: order_value, ptime: prep_time, cls: urgent};
		end
		if (state_q == tcoq_pkg::S_MARK) begin
			pos_q     <= (op_q == tcoq_pkg::OP_INSERT) ? ins_pos : del_pos;
			hit_any_q <= del_hit;
			full_q    <= (occ_q >= CW'(DEPTH));
			sum_q     <= '0;
			max_q     <= '0;
			nmatch_q  <= '0;
		end
		// totals and match count over the live entries
		if (state_q == tcoq_pkg::S_STATS && rot_en && cur_live) begin
			sum_q <= sum_next[22] ? tcoq_pkg::SUM_LIMIT : sum_next[21:0];
			if (ent[0].ptime > max_q) begin
				max_q <= ent[0].ptime;
			end
			if (cur_hit && nmatch_q != 7'(tcoq_pkg::MAX_RESULTS)) begin
				nmatch_q <= nmatch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cnt_q  <= cnt_now;
			tsum_q <= sum_q;
			tmax_q <= max_q;
		end
		if (emit_hit) begin
			st_q   <= tcoq_pkg::ST_OK;
			fv_q   <= ent[0].value;
			ft_q   <= ent[0].ptime;
			last_q <= ((nres_q + 7'd1) == nmatch_q);
		end else if (emit_end) begin
			fv_q   <= '0;
			ft_q   <= '0;
			last_q <= 1'b1;
			case (op_q)
				tcoq_pkg::OP_INSERT: st_q <= full_q ? tcoq_pkg::ST_FULL : tcoq_pkg::ST_OK;
				tcoq_pkg::OP_REMOVE: st_q <= hit_any_q ? tcoq_pkg::ST_OK :
					tcoq_pkg::ST_NOTFOUND;
				tcoq_pkg::OP_SEARCH: st_q <= tcoq_pkg::ST_NOTFOUND;
				default: st_q <= tcoq_pkg::ST_OK;
			endcase
		end
	end

	assign out_valid   = ov_q;
	assign status      = st_q;
	assign found_value = fv_q;
	assign found_time  = ft_q;
	assign entry_count = cnt_q;
	assign time_sum    = tsum_q;
	assign time_max    = tmax_q;
	assign last        = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH)) else $error("occupancy above depth");
	a_rot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rot_q <= CW'(DEPTH)) else $error("rotation overrun");
	a_accept_mark: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == tcoq_pkg::S_MARK)
		else $error("accepted transaction not started");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(found_value) && $stable(found_time) && $stable(entry_count) &&
		$stable(time_sum) && $stable(time_max) && $stable(last))
		else $error("result changed while stalled");

endmodule

// ----- test/tb_two_class_order_queue.sv -----
`timescale 1ns / 1ps

module tb_two_class_order_queue;

	localparam int QDEPTH = tcoq_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] fval;
		logic [15:0] ftime;
		logic [6:0]  count;
		logic [21:0] tsum;
		logic [15:0] tmax;
		logic        last;
	} result_t;

	typedef struct {
		tcoq_pkg::op_t     op;
		logic [15:0]       id;
		logic [23:0]       val;
		logic [15:0]       ptime;
		logic              urg;
		bit                typed;
		tcoq_pkg::status_t want_status;
		int                want_count;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [15:0] order_id;
	logic [23:0] order_value;
	logic [15:0] prep_time;
	logic        urgent;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [23:0] found_value;
	logic [15:0] found_time;
	logic [6:0]  entry_count;
	logic [21:0] time_sum;
	logic [15:0] time_max;
	logic        last;

	two_class_order_queue dut (.*);

	// shadow copy of the queue contents
	logic [15:0] q_id[QDEPTH];
	logic [23:0] q_val[QDEPTH];
	logic [15:0] q_time[QDEPTH];
	logic        q_cls[QDEPTH];
	int          q_len;

	result_t pending[$];
	int      errors;
	int      row_errors;
	int      n_items;
	int      n_results;
	int      n_full;
	int      n_miss;
	int      n_multi;
	longint  cycles;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout at %0t", $time);
				$display("tb_two_class_order_queue: FAIL");
				$finish;
			end
		end
	end

	function automatic result_t make_result(logic [1:0] st, logic [23:0] v, logic [15:0] t,
			logic lst);
		result_t r;
		int s;
		int m;
		s = 0;
		m = 0;
		for (int i = 0; i < q_len; i++) begin
			s += q_time[i];
			if (q_time[i] > m) m = q_time[i];
		end
		if (s > tcoq_pkg::SUM_LIMIT) s = tcoq_pkg::SUM_LIMIT;
		r.status = st;
		r.fval = v;
		r.ftime = t;
		r.count = (q_len > tcoq_pkg::COUNT_LIMIT) ? tcoq_pkg::COUNT_LIMIT : q_len[6:0];
		r.tsum = s[21:0];
		r.tmax = m[15:0];
		r.last = lst;
		return r;
	endfunction

	// applies one transaction to the shadow queue and queues the results it implies
	task automatic predict_order(tcoq_pkg::op_t o, logic [15:0] id, logic [23:0] v,
			logic [15:0] t, logic u);
		int pos;
		int hits;
		int n;
		bit hit;
		case (o)
			tcoq_pkg::OP_INSERT: begin
				if (q_len >= QDEPTH) begin
					pending.push_back(make_result(tcoq_pkg::ST_FULL, '0, '0, 1'b1));
					n_full++;
				end else begin
					pos = q_len;
					while (pos > 0 && q_cls[pos-1] < u) begin
						q_id[pos] = q_id[pos-1];
						q_val[pos] = q_val[pos-1];
						q_time[pos] = q_time[pos-1];
						q_cls[pos] = q_cls[pos-1];
						pos--;
					end
					q_id[pos] = id;
					q_val[pos] = v;
					q_time[pos] = t;
					q_cls[pos] = u;
					q_len++;
					pending.push_back(make_result(tcoq_pkg::ST_OK, '0, '0, 1'b1));
				end
			end
			tcoq_pkg::OP_REMOVE: begin
				hit = 0;
				pos = 0;
				for (int i = 0; i < q_len; i++)
					if (q_id[i] == id) begin
						pos = i;
						hit = 1;
					end
				if (!hit) begin
					pending.push_back(make_result(tcoq_pkg::ST_NOTFOUND, '0, '0, 1'b1));
					n_miss++;
				end else begin
					for (int i = pos; i + 1 < q_len; i++) begin
						q_id[i] = q_id[i+1];
						q_val[i] = q_val[i+1];
						q_time[i] = q_time[i+1];
						q_cls[i] = q_cls[i+1];
					end
					q_len--;
					pending.push_back(make_result(tcoq_pkg::ST_OK, '0, '0, 1'b1));
				end
			end
			tcoq_pkg::OP_SEARCH: begin
				hits = 0;
				for (int i = 0; i < q_len; i++)
					if (q_id[i] == id) hits++;
				if (hits == 0) begin
					pending.push_back(make_result(tcoq_pkg::ST_NOTFOUND, '0, '0, 1'b1));
					n_miss++;
				end else begin
					if (hits > tcoq_pkg::MAX_RESULTS) hits = tcoq_pkg::MAX_RESULTS;
					if (hits > 1) n_multi++;
					n = 0;
					for (int i = 0; i < q_len && n < hits; i++)
						if (q_id[i] == id) begin
							n++;
							pending.push_back(make_result(tcoq_pkg::ST_OK, q_val[i],
								q_time[i], n == hits));
						end
				end
			end
			default: pending.push_back(make_result(tcoq_pkg::ST_OK, '0, '0, 1'b1));
		endcase
	endtask

	// valid stays up after acceptance until the next transaction or an idle gap
	task automatic send_order(tcoq_pkg::op_t o, logic [15:0] id, logic [23:0] v,
			logic [15:0] t, logic u);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		order_id <= id;
		order_value <= v;
		prep_time <= t;
		urgent <= u;
		do @(posedge clk); while (!in_ready);
		predict_order(o, id, v, t, u);
		n_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
	endtask

	// receiver with random stalls
	always @(posedge clk) begin
		result_t got;
		result_t exp;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{status, found_value, found_time, entry_count, time_sum, time_max,
					last};
				n_results++;
				if (pending.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					exp = pending.pop_front();
					if (got.status !== exp.status) begin
						$display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
						errors++;
					end
					if (got.fval !== exp.fval) begin
						$display("%0t: found_value exp %0d got %0d", $time, exp.fval, got.fval);
						errors++;
					end
					if (got.ftime !== exp.ftime) begin
						$display("%0t: found_time exp %0d got %0d", $time, exp.ftime, got.ftime);
						errors++;
					end
					if (got.count !== exp.count) begin
						$display("%0t: entry_count exp %0d got %0d", $time, exp.count, got.count);
						errors++;
					end
					if (got.tsum !== exp.tsum) begin
						$display("%0t: time_sum exp %0d got %0d", $time, exp.tsum, got.tsum);
						errors++;
					end
					if (got.tmax !== exp.tmax) begin
						$display("%0t: time_max exp %0d got %0d", $time, exp.tmax, got.tmax);
						errors++;
					end
					if (got.last !== exp.last) begin
						$display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 49) == 0) out_ready <= 1'b0;
			else if (!out_ready && $urandom_range(0, 3) == 0) out_ready <= 1'b1;
			else if (out_ready && $urandom_range(0, 5) == 0) out_ready <= 1'b0;
			else out_ready <= out_ready | ($urandom_range(0, 2) == 0);
		end
	end

	function automatic logic [15:0] pick_id();
		if (q_len > 0 && $urandom_range(0, 3) != 0)
			return q_id[$urandom_range(0, q_len - 1)];
		return ($urandom_range(0, 1)) ? 16'($urandom_range(0, 7)) : 16'($urandom);
	endfunction

	dir_row_t dir_rows[$];

	initial begin
		tcoq_pkg::op_t o;
		int            r;
		errors = 0;
		row_errors = 0;
		n_items = 0;
		n_results = 0;
		n_full = 0;
		n_miss = 0;
		n_multi = 0;
		q_len = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = tcoq_pkg::OP_INSERT;
		order_id = '0;
		order_value = '0;
		prep_time = '0;
		urgent = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; typed rows carry status and count worked out by hand
		dir_rows = '{
			'{tcoq_pkg::OP_SEARCH, 16'h0000, 24'h0, 16'h0, 1'b0, 1, tcoq_pkg::ST_NOTFOUND, 0},
			'{tcoq_pkg::OP_REMOVE, 16'hffff, 24'h0, 16'h0, 1'b0, 1, tcoq_pkg::ST_NOTFOUND, 0},
			'{tcoq_pkg::OP_NONE, 16'hffff, 24'hffffff, 16'hffff, 1'b1, 1, tcoq_pkg::ST_OK, 0},
			'{tcoq_pkg::OP_INSERT, 16'h0000, 24'h000000, 16'h0000, 1'b0, 1, tcoq_pkg::ST_OK, 1},
			'{tcoq_pkg::OP_INSERT, 16'hffff, 24'hffffff, 16'hffff, 1'b1, 1, tcoq_pkg::ST_OK, 2},
			'{tcoq_pkg::OP_INSERT, 16'h0005, 24'h123456, 16'h0100, 1'b0, 1, tcoq_pkg::ST_OK, 3},
			'{tcoq_pkg::OP_INSERT, 16'h0005, 24'h654321, 16'h0200, 1'b1, 1, tcoq_pkg::ST_OK, 4},
			'{tcoq_pkg::OP_INSERT, 16'h0005, 24'haaaaaa, 16'h5555, 1'b0, 1, tcoq_pkg::ST_OK, 5},
			'{tcoq_pkg::OP_SEARCH, 16'h0005, 24'h0, 16'h0, 1'b0, 0, tcoq_pkg::ST_OK, 0},
			'{tcoq_pkg::OP_SEARCH, 16'hffff, 24'h0, 16'h0, 1'b0, 0, tcoq_pkg::ST_OK, 0},
			'{tcoq_pkg::OP_SEARCH, 16'h0000, 24'h0, 16'h0, 1'b0, 0, tcoq_pkg::ST_OK, 0},
			'{tcoq_pkg::OP_REMOVE, 16'h0005, 24'h0, 16'h0, 1'b0, 1, tcoq_pkg::ST_OK, 4},
			'{tcoq_pkg::OP_SEARCH, 16'h0005, 24'h0, 16'h0, 1'b0, 0, tcoq_pkg::ST_OK, 0},
			'{tcoq_pkg::OP_REMOVE, 16'hffff, 24'h0, 16'h0, 1'b0, 1, tcoq_pkg::ST_OK, 3},
			'{tcoq_pkg::OP_NONE, 16'h0005, 24'h0, 16'h0, 1'b0, 0, tcoq_pkg::ST_OK, 0},
			'{tcoq_pkg::OP_REMOVE, 16'h1234, 24'h0, 16'h0, 1'b0, 1, tcoq_pkg::ST_NOTFOUND, 3}
		};
		foreach (dir_rows[i]) begin
			send_order(dir_rows[i].op, dir_rows[i].id, dir_rows[i].val, dir_rows[i].ptime,
				dir_rows[i].urg);
			if (dir_rows[i].typed && (pending[$].status !== dir_rows[i].want_status ||
					pending[$].count !== dir_rows[i].want_count)) begin
				$display("%0t: row %0d exp status %0d count %0d got status %0d count %0d",
					$time, i, dir_rows[i].want_status, dir_rows[i].want_count,
					pending[$].status, pending[$].count);
				row_errors++;
			end
		end

		// fill to full with repeated ids, then overflow and search the crowd
		while (q_len < QDEPTH)
			send_order(tcoq_pkg::OP_INSERT, 16'($urandom_range(0, 3)), 24'($urandom),
				16'($urandom), 1'($urandom));
		send_order(tcoq_pkg::OP_INSERT, 16'h7777, 24'($urandom), 16'hffff, 1'b1);
		send_order(tcoq_pkg::OP_INSERT, 16'h7777, 24'($urandom), 16'h0000, 1'b0);
		for (int k = 0; k < 4; k++) send_order(tcoq_pkg::OP_SEARCH, 16'(k), '0, '0, 1'b0);

		// hold the sender until the block has answered everything
		wait_drained();

		for (int k = 0; k < 127; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3) o = tcoq_pkg::OP_NONE;
			else if (q_len < 8 || r < 45) o = tcoq_pkg::OP_INSERT;
			else if (r < 72) o = tcoq_pkg::OP_REMOVE;
			else o = tcoq_pkg::OP_SEARCH;
			send_order(o, (o == tcoq_pkg::OP_INSERT && $urandom_range(0, 1)) ?
				16'($urandom) : pick_id(), 24'($urandom), 16'($urandom), 1'($urandom));
			if (k == 60) wait_drained();
		end

		wait_drained();
		repeat (3 * QDEPTH + 20) @(posedge clk);
		$display("covered %0d transactions, %0d results: %0d full, %0d not found, %0d multi-hit",
			n_items, n_results, n_full, n_miss, n_multi);
		if (errors == 0 && row_errors == 0 && pending.size() == 0)
			$display("tb_two_class_order_queue: PASS");
		else
			$display("tb_two_class_order_queue: FAIL");
		$finish;
	end

endmodule
